[sv/assert_macros.svh]
// Assertion macros used by the RTL of the maze path counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/maze_pkg.sv]
// Types, constants, codes and control store of the maze path counter.
package maze_pkg;

    localparam int GRID_MAX  = 5;
    localparam int CELLS     = GRID_MAX * GRID_MAX;
    localparam int CELL_IW   = $clog2(CELLS);
    localparam int DEPTH_W   = $clog2(CELLS + 1);
    localparam int COORD_W   = 3;
    localparam int COUNT_W   = 20;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;
    localparam int DIR_W     = 3;
    localparam int UPC_W     = 3;
    localparam int CODE_W    = 3;

    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_COL = 2'd3;

    localparam logic [COORD_W-1:0] GRID_RESET     = 3'd5;
    localparam logic [COORD_W-1:0] GOAL_ROW_RESET = 3'd2;
    localparam logic [COORD_W-1:0] GOAL_COL_RESET = 3'd2;
    localparam logic [COORD_W-1:0] GRID_LIMIT     = COORD_W'(GRID_MAX);

    localparam logic [DIR_W-1:0] DIR_ROW_INC = 3'd0;
    localparam logic [DIR_W-1:0] DIR_ROW_DEC = 3'd1;
    localparam logic [DIR_W-1:0] DIR_COL_INC = 3'd2;
    localparam logic [DIR_W-1:0] DIR_COL_DEC = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE    = 3'd4;

    localparam logic [CODE_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [CODE_W-1:0] ACT_LOAD  = 3'd1;
    localparam logic [CODE_W-1:0] ACT_ENTER = 3'd2;
    localparam logic [CODE_W-1:0] ACT_ITER  = 3'd3;
    localparam logic [CODE_W-1:0] ACT_EMIT  = 3'd4;

    localparam logic [CODE_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [CODE_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [CODE_W-1:0] COND_NO_IN    = 3'd2;
    localparam logic [CODE_W-1:0] COND_END      = 3'd3;
    localparam logic [CODE_W-1:0] COND_ADVANCE  = 3'd4;
    localparam logic [CODE_W-1:0] COND_OUT_BUSY = 3'd5;

    localparam logic [UPC_W-1:0] UPC_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] UPC_ENTER = 3'd1;
    localparam logic [UPC_W-1:0] UPC_TEST  = 3'd2;
    localparam logic [UPC_W-1:0] UPC_STEP  = 3'd3;
    localparam logic [UPC_W-1:0] UPC_LOOP  = 3'd4;
    localparam logic [UPC_W-1:0] UPC_EMIT  = 3'd5;
    localparam logic [UPC_W-1:0] UPC_WRAP  = 3'd6;

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] path_count;
        logic               count_saturated;
    } t_out_beat;

    typedef struct packed {
        logic [CODE_W-1:0] act;
        logic [CODE_W-1:0] cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    // Cell number of an in-bounds cell, row-major with stride GRID_MAX.
    function automatic logic [CELL_IW-1:0] cell_idx(input logic [COORD_W-1:0] row,
                                                     input logic [COORD_W-1:0] col);
        logic [2*COORD_W-1:0] sum;
        sum = (2*COORD_W)'(row) * (2*COORD_W)'(GRID_MAX) + (2*COORD_W)'(col);
        return sum[CELL_IW-1:0];
    endfunction

    // Control store: a taken condition jumps to the target, else the next word follows.
    function automatic t_uword ucode_rom(input logic [UPC_W-1:0] upc);
        t_uword w;
        case (upc)
            UPC_IDLE:  w = '{act: ACT_LOAD,  cond: COND_NO_IN,    target: UPC_IDLE};
            UPC_ENTER: w = '{act: ACT_ENTER, cond: COND_NEVER,    target: UPC_IDLE};
            UPC_TEST:  w = '{act: ACT_NONE,  cond: COND_END,      target: UPC_EMIT};
            UPC_STEP:  w = '{act: ACT_ITER,  cond: COND_ADVANCE,  target: UPC_ENTER};
            UPC_LOOP:  w = '{act: ACT_NONE,  cond: COND_ALWAYS,   target: UPC_TEST};
            UPC_EMIT:  w = '{act: ACT_EMIT,  cond: COND_OUT_BUSY, target: UPC_EMIT};
            UPC_WRAP:  w = '{act: ACT_NONE,  cond: COND_ALWAYS,   target: UPC_IDLE};
            default:   w = '{act: ACT_NONE,  cond: COND_ALWAYS,   target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

[sv/maze_simple_path_counter.sv]
// Top level of the maze simple-path counter: microcoded depth-first search.
//
// A start cell arrives as one beat on the input channel (i_in_valid/o_in_ready);
// one beat with the number of simple four-neighbour paths from that cell to the
// goal leaves on the output channel (o_out_valid/i_out_ready). The user must write
// the maze map, the grid size in use and the goal cell on the configuration port
// only while the block is idle; the block itself does not enforce this. A control
// store of seven words steps a small datapath with an explicit direction stack
// and a visited mask, one word per cycle. Each cell pushed on the stack takes
// its four direction tries and then its pop. The next start cell is taken only
// after the result of the current search has been written to the output register;
// a saturated count ends the search early. A stalled receiver holds the result
// in the output register; the next search may run meanwhile and waits at its end
// until the register is free. Reset clears the sequencer, the stack depth, the
// mask and the output valid, and loads the configuration registers with an empty
// map, grid size 5 and goal (2,2).
`include "assert_macros.svh"

module maze_simple_path_counter
    import maze_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out
);

    logic [CELLS-1:0]   r_open_map, n_open_map;
    logic [COORD_W-1:0] r_grid, n_grid;
    logic [COORD_W-1:0] r_goal_row, n_goal_row;
    logic [COORD_W-1:0] r_goal_col, n_goal_col;

    logic [UPC_W-1:0]   r_upc, n_upc;
    logic [CELLS-1:0]   r_visited, n_visited;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COORD_W:0]   r_cur_row, n_cur_row;
    logic [COORD_W:0]   r_cur_col, n_cur_col;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    logic [DIR_W-1:0]   r_stk_dir [CELLS];
    logic [DIR_W-1:0]   n_stk_dir [CELLS];
    logic [COORD_W-1:0] r_stk_row [CELLS];
    logic [COORD_W-1:0] n_stk_row [CELLS];
    logic [COORD_W-1:0] r_stk_col [CELLS];
    logic [COORD_W-1:0] n_stk_col [CELLS];

    t_uword             uw;
    logic               in_accept;
    logic               out_busy;
    logic               take;
    logic [COORD_W-1:0] n_use;
    logic [DEPTH_W-1:0] top;
    logic [DIR_W-1:0]   top_dir;
    logic [COORD_W:0]   top_row_x;
    logic [COORD_W:0]   top_col_x;
    logic               at_goal;
    logic               in_bounds;
    logic [CELL_IW-1:0] cur_idx;
    logic               cell_free;
    logic               search_end;

    always_comb begin
        uw         = ucode_rom(r_upc);
        o_in_ready = (uw.act == ACT_LOAD);
        in_accept  = i_in_valid && o_in_ready;
        out_busy   = r_out_valid && !i_out_ready;

        n_use      = (r_grid > GRID_LIMIT) ? GRID_LIMIT : r_grid;
        top        = r_depth - DEPTH_W'(1);
        top_dir    = r_stk_dir[top];
        top_row_x  = {1'b0, r_stk_row[top]};
        top_col_x  = {1'b0, r_stk_col[top]};
        at_goal    = (r_cur_row == {1'b0, r_goal_row}) && (r_cur_col == {1'b0, r_goal_col});
        in_bounds  = !r_cur_row[COORD_W] && !r_cur_col[COORD_W]
                     && (r_cur_row[COORD_W-1:0] < n_use) && (r_cur_col[COORD_W-1:0] < n_use);
        cur_idx    = cell_idx(r_cur_row[COORD_W-1:0], r_cur_col[COORD_W-1:0]);
        cell_free  = in_bounds && r_open_map[cur_idx] && !r_visited[cur_idx];
        search_end = (r_depth == '0) || (r_count == COUNT_TOP);

        n_open_map = r_open_map;
        n_grid     = r_grid;
        n_goal_row = r_goal_row;
        n_goal_col = r_goal_col;
        n_visited  = r_visited;
        n_depth    = r_depth;
        n_count    = r_count;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_out      = r_out;
        n_stk_dir  = r_stk_dir;
        n_stk_row  = r_stk_row;
        n_stk_col  = r_stk_col;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OPEN_MAP: n_open_map = i_cfg_data[CELLS-1:0];
                CFG_GRID:     n_grid     = i_cfg_data[COORD_W-1:0];
                CFG_GOAL_ROW: n_goal_row = i_cfg_data[COORD_W-1:0];
                CFG_GOAL_COL: n_goal_col = i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end

        case (uw.act)
            ACT_LOAD: begin
                if (in_accept) begin
                    n_cur_row = {1'b0, i_in.start_row};
                    n_cur_col = {1'b0, i_in.start_col};
                    n_visited = '0;
                    n_depth   = '0;
                    n_count   = '0;
                end
            end
            ACT_ENTER: begin
                if (at_goal) begin
                    if (r_count != COUNT_TOP) begin
                        n_count = r_count + COUNT_W'(1);
                    end
                end else if (cell_free) begin
                    n_visited[cur_idx] = 1'b1;
                    n_stk_dir[r_depth] = DIR_ROW_INC;
                    n_stk_row[r_depth] = r_cur_row[COORD_W-1:0];
                    n_stk_col[r_depth] = r_cur_col[COORD_W-1:0];
                    n_depth            = r_depth + DEPTH_W'(1);
                end
            end
            ACT_ITER: begin
                if (top_dir >= DIR_DONE) begin
                    n_visited[cell_idx(r_stk_row[top], r_stk_col[top])] = 1'b0;
                    n_depth = top;
                end else begin
                    n_stk_dir[top] = top_dir + DIR_W'(1);
                    n_cur_row      = top_row_x;
                    n_cur_col      = top_col_x;
                    case (top_dir)
                        DIR_ROW_INC: n_cur_row = top_row_x + (COORD_W+1)'(1);
                        DIR_ROW_DEC: n_cur_row = top_row_x - (COORD_W+1)'(1);
                        DIR_COL_INC: n_cur_col = top_col_x + (COORD_W+1)'(1);
                        DIR_COL_DEC: n_cur_col = top_col_x - (COORD_W+1)'(1);
                        default: ;
                    endcase
                end
            end
            ACT_EMIT: begin
                if (!out_busy) begin
                    n_out.path_count      = r_count;
                    n_out.count_saturated = (r_count == COUNT_TOP);
                end
            end
            default: ;
        endcase

        if (uw.act == ACT_EMIT && !out_busy) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        case (uw.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_IN:    take = !i_in_valid;
            COND_END:      take = search_end;
            COND_ADVANCE:  take = (top_dir < DIR_DONE);
            COND_OUT_BUSY: take = out_busy;
            default:       take = 1'b1;
        endcase
        n_upc = take ? uw.target : r_upc + UPC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_map  <= '0;
            r_grid      <= GRID_RESET;
            r_goal_row  <= GOAL_ROW_RESET;
            r_goal_col  <= GOAL_COL_RESET;
            r_upc       <= UPC_IDLE;
            r_visited   <= '0;
            r_depth     <= '0;
            r_count     <= '0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_open_map  <= n_open_map;
            r_grid      <= n_grid;
            r_goal_row  <= n_goal_row;
            r_goal_col  <= n_goal_col;
            r_upc       <= n_upc;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_cur_row   <= n_cur_row;
            r_cur_col   <= n_cur_col;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_stk_dir <= n_stk_dir;
        r_stk_row <= n_stk_row;
        r_stk_col <= n_stk_col;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_NEXT(a_load_clears, in_accept, (r_upc == UPC_ENTER) && (r_depth == '0) && (r_visited == '0))
    `ASSERT_IMPL(a_mask_matches_depth, 1'b1, $countones(r_visited) == 32'(r_depth))
    `ASSERT_IMPL(a_result_from_emit, $rose(o_out_valid), $past(r_upc) == UPC_EMIT)

endmodule
